[hw/rtl/cbpi_pkg.sv]
// shared constants, codes and handshake structs of the convex brush point-inside block
package cbpi_pkg;

    localparam int MAX_PLANES = 64;
    localparam int ADDR_W     = $clog2(MAX_PLANES);
    localparam int CNT_W      = $clog2(MAX_PLANES + 1);
    localparam int HELD_W     = 7;

    localparam int NORM_W     = 16;
    localparam int DIST_W     = 32;
    localparam int COORD_W    = 32;
    localparam int ENTRY_W    = 3 * NORM_W + DIST_W;

    localparam int FRAC_SH    = 14;
    localparam int TERM_W     = 48;
    localparam int PROD_W     = 64;
    localparam int AXIS_W     = PROD_W - FRAC_SH;
    localparam int SUM_W      = AXIS_W + 2;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_QUERY = 2'd1,
        K_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic valid;
        logic last;
    } t_pipe_ctl;

    typedef struct packed {
        logic valid;
        logic last;
        logic outside;
    } t_pipe_res;

endpackage

[hw/rtl/cbpi_plane_ram.sv]
// plane table memory: one write port, one registered read port
module cbpi_plane_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/cbpi_dot_pipe.sv]
// per-plane distance pipeline: d = dot(p + n*dist, n) compared against the margin
module cbpi_dot_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbpi_pkg::t_pipe_ctl                 i_ctl,
    input  logic [cbpi_pkg::ENTRY_W-1:0]        i_entry,
    input  logic signed [cbpi_pkg::COORD_W-1:0] i_px,
    input  logic signed [cbpi_pkg::COORD_W-1:0] i_py,
    input  logic signed [cbpi_pkg::COORD_W-1:0] i_pz,
    input  logic signed [cbpi_pkg::DIST_W-1:0]  i_margin,
    output cbpi_pkg::t_pipe_res                 o_res
);

    localparam int NW = cbpi_pkg::NORM_W;
    localparam int TW = cbpi_pkg::TERM_W;
    localparam int PW = cbpi_pkg::PROD_W;
    localparam int AW = cbpi_pkg::AXIS_W;
    localparam int SW = cbpi_pkg::SUM_W;
    localparam int SH = cbpi_pkg::FRAC_SH;

    logic signed [NW-1:0] e_nx, e_ny, e_nz;
    logic signed [cbpi_pkg::DIST_W-1:0] e_dist;

    assign e_nx   = i_entry[NW-1:0];
    assign e_ny   = i_entry[2*NW-1:NW];
    assign e_nz   = i_entry[3*NW-1:2*NW];
    assign e_dist = i_entry[cbpi_pkg::ENTRY_W-1:3*NW];

    // stage 1: n * dist
    cbpi_pkg::t_pipe_ctl r_c1, r_c2, r_c3, r_c4;
    logic signed [NW-1:0] r_n1x, r_n1y, r_n1z;
    logic signed [TW-1:0] r_nd_x, r_nd_y, r_nd_z;
    // stage 2: t = p * 2^14 + n * dist
    logic signed [NW-1:0] r_n2x, r_n2y, r_n2z;
    logic signed [TW-1:0] r_t_x, r_t_y, r_t_z;
    // stage 3: t * n
    logic signed [PW-1:0] r_m_x, r_m_y, r_m_z;
    // stage 4: floor shift and sum
    logic signed [SW-1:0] r_d;

    logic signed [AW-1:0] u_x, u_y, u_z;
    logic signed [SW-1:0] n_d;
    logic signed [cbpi_pkg::DIST_W+SH-1:0] lim_s;
    logic signed [SW-1:0] lim;

    // arithmetic right shift of the top bits is a floor toward minus infinity
    assign u_x = r_m_x[PW-1:SH];
    assign u_y = r_m_y[PW-1:SH];
    assign u_z = r_m_z[PW-1:SH];
    assign n_d = SW'(u_x) + SW'(u_y) + SW'(u_z);

    assign lim_s = {i_margin, {SH{1'b0}}};
    assign lim   = SW'(lim_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
        end else begin
            r_c1 <= i_ctl;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n1x  <= e_nx;
        r_n1y  <= e_ny;
        r_n1z  <= e_nz;
        r_nd_x <= TW'(e_nx) * TW'(e_dist);
        r_nd_y <= TW'(e_ny) * TW'(e_dist);
        r_nd_z <= TW'(e_nz) * TW'(e_dist);

        r_n2x  <= r_n1x;
        r_n2y  <= r_n1y;
        r_n2z  <= r_n1z;
        r_t_x  <= (TW'(i_px) <<< SH) + r_nd_x;
        r_t_y  <= (TW'(i_py) <<< SH) + r_nd_y;
        r_t_z  <= (TW'(i_pz) <<< SH) + r_nd_z;

        r_m_x  <= PW'(r_t_x) * PW'(r_n2x);
        r_m_y  <= PW'(r_t_y) * PW'(r_n2y);
        r_m_z  <= PW'(r_t_z) * PW'(r_n2z);

        r_d    <= n_d;
    end

    assign o_res.valid   = r_c4.valid;
    assign o_res.last    = r_c4.last;
    assign o_res.outside = (r_d >= lim);

endmodule

[hw/rtl/convex_brush_point_inside.sv]
// convex brush point-inside test: plane table, query sweep and result register
// add and clear finish while idle and do not stall the input; a query stalls the input
// until its result is registered, with one memory read per plane feeding a four-stage
// distance pipeline; an empty-table query skips the sweep and goes straight to the result
// the result is held in an output register, so the next item is taken while it waits
// synchronous active-low reset empties the table and clears the margin to zero
module convex_brush_point_inside (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic signed [cbpi_pkg::NORM_W-1:0]  i_normal_x,
    input  logic signed [cbpi_pkg::NORM_W-1:0]  i_normal_y,
    input  logic signed [cbpi_pkg::NORM_W-1:0]  i_normal_z,
    input  logic signed [cbpi_pkg::DIST_W-1:0]  i_plane_distance,
    input  logic signed [cbpi_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [cbpi_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [cbpi_pkg::COORD_W-1:0] i_point_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_inside_res,
    output logic [cbpi_pkg::HELD_W-1:0]         o_planes_held,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic signed [cbpi_pkg::DIST_W-1:0]  i_cfg_data
);

    localparam int AW = cbpi_pkg::ADDR_W;
    localparam int CW = cbpi_pkg::CNT_W;

    cbpi_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_outside, n_outside;
    logic signed [cbpi_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic signed [cbpi_pkg::DIST_W-1:0]  r_margin;
    cbpi_pkg::t_pipe_ctl r_rd_ctl, n_rd_ctl;
    cbpi_pkg::t_pipe_res pipe_res;

    logic r_out_valid, n_out_valid;
    logic r_out_inside, n_out_inside;
    logic [cbpi_pkg::HELD_W-1:0] r_out_held, n_out_held;

    logic in_xfer, out_xfer, ram_we, pt_load;
    logic [cbpi_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

    assign o_in_stall = (r_state != cbpi_pkg::S_IDLE);
    assign in_xfer    = i_in_valid & ~o_in_stall;
    assign out_xfer   = r_out_valid & ~i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign ram_wdata = {i_plane_distance, i_normal_z, i_normal_y, i_normal_x};

    // writes happen only when idle and reads only during a sweep, so they never overlap
    cbpi_plane_ram #(
        .WIDTH (cbpi_pkg::ENTRY_W),
        .DEPTH (cbpi_pkg::MAX_PLANES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    cbpi_dot_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_rd_ctl),
        .i_entry  (ram_rdata),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_pz     (r_pz),
        .i_margin (r_margin),
        .o_res    (pipe_res)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_outside    = r_outside;
        n_rd_ctl     = '0;
        n_out_valid  = r_out_valid & ~out_xfer;
        n_out_inside = r_out_inside;
        n_out_held   = r_out_held;
        ram_we       = 1'b0;
        pt_load      = 1'b0;

        // any plane at or above the margin marks the point outside
        if (pipe_res.valid) begin
            n_outside = r_outside | pipe_res.outside;
        end

        unique case (r_state)
            cbpi_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (cbpi_pkg::t_kind'(i_kind))
                        cbpi_pkg::K_ADD: begin
                            if (r_count < CW'(cbpi_pkg::MAX_PLANES)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        cbpi_pkg::K_QUERY: begin
                            pt_load   = 1'b1;
                            n_outside = 1'b0;
                            n_addr    = '0;
                            if (r_count == '0) begin
                                n_state = cbpi_pkg::S_DONE;
                            end else begin
                                n_state = cbpi_pkg::S_SCAN;
                            end
                        end
                        cbpi_pkg::K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cbpi_pkg::S_SCAN: begin
                n_rd_ctl.valid = 1'b1;
                n_rd_ctl.last  = (CW'(r_addr) == r_count - 1'b1);
                n_addr         = r_addr + 1'b1;
                if (n_rd_ctl.last) begin
                    n_state = cbpi_pkg::S_WAIT;
                end
            end
            cbpi_pkg::S_WAIT: begin
                if (pipe_res.valid && pipe_res.last) begin
                    n_state = cbpi_pkg::S_DONE;
                end
            end
            cbpi_pkg::S_DONE: begin
                if (!r_out_valid || out_xfer) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = ~r_outside;
                    n_out_held   = cbpi_pkg::HELD_W'(r_count);
                    n_state      = cbpi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cbpi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbpi_pkg::S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_outside   <= 1'b0;
            r_rd_ctl    <= '0;
            r_out_valid <= 1'b0;
            r_margin    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_outside   <= n_outside;
            r_rd_ctl    <= n_rd_ctl;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inside <= n_out_inside;
        r_out_held   <= n_out_held;
        if (pt_load) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_inside_res  = r_out_inside;
    assign o_planes_held = r_out_held;

endmodule
